/* sv/abb_pkg.sv */
// ----------------------------------------------------------------------------
// abb_pkg
// Shared types and constants for the atlas blit with edge border unit.
// ----------------------------------------------------------------------------
package abb_pkg;

   localparam int ADDR_W     = 24;
   localparam int COLOR_W    = 32;
   localparam int DIM_REG_W  = 10;
   localparam int PITCH_W    = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;
   localparam int MAX_DIM_DEFAULT = 1023;
   localparam int QUEUE_DEPTH = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ATLAS_WIDTH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_COLUMN = 2'd3;

   typedef logic [1:0] span_type;   // count minus one, 0..2

   // One classified texel, waiting for the write sequencer.
   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [ADDR_W-1:0]  first_addr;  // address of the first write
      span_type           last_col;    // index of the last column written
      span_type           last_row;    // index of the last row written
      logic               done;        // last texel of the sub-texture
   } entry_type;

   // Handshake between the queue and its neighbors.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* sv/abb_front.sv */
// ----------------------------------------------------------------------------
// abb_front
// Accepts texels, tracks the source position and classifies edges.
// ----------------------------------------------------------------------------
module abb_front #(
   parameter int MAX_DIM = abb_pkg::MAX_DIM_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [abb_pkg::COLOR_W-1:0]       req_tdata,
   input  logic [abb_pkg::DIM_REG_W-1:0]     tex_width,
   input  logic [abb_pkg::DIM_REG_W-1:0]     tex_height,
   input  logic [abb_pkg::PITCH_W-1:0]       atlas_width,
   input  logic [abb_pkg::PITCH_W-1:0]       dest_column,
   input  abb_pkg::queue_status_type         queue_status,
   output logic                              push,
   output abb_pkg::entry_type                push_entry
);
   import abb_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   logic [DIM_W-1:0]  x_ff, x_in;
   logic [DIM_W-1:0]  y_ff, y_in;
   logic [ADDR_W-1:0] row_base_ff, row_base_in;

   logic [DIM_W-1:0]  w_clamp, h_clamp;
   logic              left, right, top, bottom;
   logic [ADDR_W-1:0] pitch_ext, row_ofs, col_term;

   // Clamp a size register into 1..MAX_DIM.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (int'(v) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(v);
      end
      return r;
   endfunction

   assign w_clamp = clamp_dim(tex_width);
   assign h_clamp = clamp_dim(tex_height);

   assign left   = (x_ff == '0);
   assign right  = (x_ff >= w_clamp - DIM_W'(1));
   assign top    = (y_ff == '0);
   assign bottom = (y_ff >= h_clamp - DIM_W'(1));

   assign req_tready = !queue_status.full;
   assign push       = req_tvalid && req_tready;

   assign pitch_ext = ADDR_W'(atlas_width);
   assign row_ofs   = top ? '0 : pitch_ext;
   // On the left edge the first write lands one column left of dest_column.
   assign col_term  = left ? {ADDR_W{1'b1}} : ADDR_W'(x_ff);

   always_comb begin
      push_entry.color      = req_tdata;
      push_entry.first_addr = row_base_ff + row_ofs + ADDR_W'(dest_column) + col_term;
      push_entry.last_col   = span_type'(left) + span_type'(right);
      push_entry.last_row   = span_type'(top) + span_type'(bottom);
      push_entry.done       = right && bottom;
   end

   always_comb begin
      x_in        = x_ff;
      y_in        = y_ff;
      row_base_in = row_base_ff;
      if (push) begin
         if (!right) begin
            x_in = x_ff + DIM_W'(1);
         end else if (!bottom) begin
            x_in        = '0;
            y_in        = y_ff + DIM_W'(1);
            row_base_in = row_base_ff + pitch_ext;
         end else begin
            x_in        = '0;
            y_in        = '0;
            row_base_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff        <= '0;
         y_ff        <= '0;
         row_base_ff <= '0;
      end else begin
         x_ff        <= x_in;
         y_ff        <= y_in;
         row_base_ff <= row_base_in;
      end
   end

endmodule

/* sv/abb_queue.sv */
// ----------------------------------------------------------------------------
// abb_queue
// Short first-in first-out queue between the front and the write sequencer.
// ----------------------------------------------------------------------------
module abb_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  abb_pkg::entry_type         push_entry,
   input  logic                       pop,
   output abb_pkg::entry_type         head,
   output abb_pkg::queue_status_type  status
);
   import abb_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* sv/abb_back.sv */
// ----------------------------------------------------------------------------
// abb_back
// Write sequencer: walks the rows and columns of the queue head, one write
// per cycle while rsp_tready allows, into a registered output stage.
// ----------------------------------------------------------------------------
module abb_back (
   input  logic                             clock,
   input  logic                             reset,
   input  abb_pkg::entry_type               head,
   input  abb_pkg::queue_status_type        queue_status,
   output logic                             pop,
   input  logic [abb_pkg::PITCH_W-1:0]      atlas_width,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [55:0]                      rsp_tdata,
   output logic                             rsp_tlast,
   output logic                             rsp_tuser
);
   import abb_pkg::*;

   span_type            col_ff, col_in;
   span_type            row_ff, row_in;
   logic [ADDR_W-1:0]   row_ofs_ff, row_ofs_in;
   logic                valid_ff, valid_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [COLOR_W-1:0]  color_ff, color_in;
   logic                last_ff, last_in;
   logic                done_ff, done_in;

   logic advance, emit, col_end, row_end;

   assign advance = !valid_ff || rsp_tready;
   assign emit    = advance && !queue_status.empty;
   assign col_end = (col_ff == head.last_col);
   assign row_end = (row_ff == head.last_row);
   assign pop     = emit && col_end && row_end;

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      row_ofs_in = row_ofs_ff;
      valid_in   = valid_ff;
      addr_in    = addr_ff;
      color_in   = color_ff;
      last_in    = last_ff;
      done_in    = done_ff;
      if (emit) begin
         valid_in = 1'b1;
         addr_in  = head.first_addr + row_ofs_ff + ADDR_W'(col_ff);
         color_in = head.color;
         last_in  = col_end && row_end;
         done_in  = col_end && row_end && head.done;
         if (!col_end) begin
            col_in = col_ff + span_type'(1);
         end else if (!row_end) begin
            col_in     = '0;
            row_in     = row_ff + span_type'(1);
            row_ofs_in = row_ofs_ff + ADDR_W'(atlas_width);
         end else begin
            col_in     = '0;
            row_in     = '0;
            row_ofs_in = '0;
         end
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         row_ofs_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         row_ofs_ff <= row_ofs_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      color_ff <= color_in;
      last_ff  <= last_in;
      done_ff  <= done_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {color_ff, addr_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

endmodule

/* sv/atlas_blit_with_edge_border_unit.sv */
// ----------------------------------------------------------------------------
// atlas_blit_with_edge_border_unit
// Blits one sub-texture into an atlas with a one-texel clamp-to-edge border.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Item
//   req_      in          one source texel, raster order
//   rsp_      out         one atlas write (address, color, run and frame marks)
//   csr_      in          one register write (index, data)
//
// The front takes one texel per cycle while the queue has room. The write
// sequencer emits one atlas write per cycle while rsp_ is not stalled; a
// texel causes one write when it is interior, up to nine for the single
// texel of a texture that is one texel wide and one texel tall.
// Reset is synchronous and clears the
// source position, queue and output stage; registers return to width 1,
// height 1, pitch 3, column 1. A stall on rsp_ backs up through the queue
// into req_tready; a gap on req_ only drains the queue.
//
module atlas_blit_with_edge_border_unit #(
   parameter int MAX_DIM = abb_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Texel input. tdata: texel_color[31:0].
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [abb_pkg::COLOR_W-1:0]         req_tdata,
   // Atlas writes. tdata: dest_address[23:0], write_color[55:24].
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [55:0]                         rsp_tdata,
   output logic                                rsp_tlast,   // last_of_run
   output logic                                rsp_tuser,   // texture_done
   // Register writes.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [abb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [abb_pkg::CSR_DATA_W-1:0]      csr_data
);
   import abb_pkg::*;

   logic [DIM_REG_W-1:0] tex_width_ff, tex_width_in;
   logic [DIM_REG_W-1:0] tex_height_ff, tex_height_in;
   logic [PITCH_W-1:0]   atlas_width_ff, atlas_width_in;
   logic [PITCH_W-1:0]   dest_column_ff, dest_column_in;

   logic             push, pop;
   entry_type        push_entry, head;
   queue_status_type queue_status;

   // Registers accept a write every cycle.
   assign csr_ready = 1'b1;

   always_comb begin
      tex_width_in   = tex_width_ff;
      tex_height_in  = tex_height_ff;
      atlas_width_in = atlas_width_ff;
      dest_column_in = dest_column_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TEX_WIDTH: begin
               tex_width_in = csr_data[DIM_REG_W-1:0];
            end
            CSR_TEX_HEIGHT: begin
               tex_height_in = csr_data[DIM_REG_W-1:0];
            end
            CSR_ATLAS_WIDTH: begin
               atlas_width_in = csr_data[PITCH_W-1:0];
            end
            CSR_DEST_COLUMN: begin
               dest_column_in = csr_data[PITCH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff   <= DIM_REG_W'(1);
         tex_height_ff  <= DIM_REG_W'(1);
         atlas_width_ff <= PITCH_W'(3);
         dest_column_ff <= PITCH_W'(1);
      end else begin
         tex_width_ff   <= tex_width_in;
         tex_height_ff  <= tex_height_in;
         atlas_width_ff <= atlas_width_in;
         dest_column_ff <= dest_column_in;
      end
   end

   // The front classifies each texel and computes its first write address.
   abb_front #(
      .MAX_DIM(MAX_DIM)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .tex_width    (tex_width_ff),
      .tex_height   (tex_height_ff),
      .atlas_width  (atlas_width_ff),
      .dest_column  (dest_column_ff),
      .queue_status (queue_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   // The queue lets the front keep accepting while the back is busy.
   abb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (queue_status)
   );

   // The back walks the writes of the queue head in row, then column, order.
   abb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .queue_status (queue_status),
      .pop          (pop),
      .atlas_width  (atlas_width_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the atlas blit with edge border unit. Source texels
// go in on req_, atlas writes come back on rsp_ and are compared in order with
// the writes predicted for every accepted texel. A short table of directed
// steps comes first, then random sub-textures under changing idle patterns.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import abb_pkg::*;

   localparam int MAX_DIM      = MAX_DIM_DEFAULT;
   localparam int RANDOM_ITEMS = 235;   // random texels
   localparam int QUIET_LIMIT  = 2000;  // cycles without any handshake before giving up
   localparam int TAIL_CYCLES  = 16;    // settle time once every write has arrived
   localparam int PHASE_CAP    = 40;    // longest run of texels in one random phase
   localparam int STRIP_PHASE  = 5;     // phase that walks a one-texel-wide strip

   // One atlas write as it leaves the block.
   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [COLOR_W-1:0] color;
      logic               last;
      logic               done;
   } atlas_write_t;

   // One row of the directed table: either a register write or a texel.
   // A texel marked typed expects a full 3x3 block of writes starting at
   // corner with the given pitch, which is what any 1x1 sub-texture produces.
   typedef struct {
      bit                    is_reg;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
      logic [COLOR_W-1:0]    color;
      bit                    typed;
      logic [ADDR_W-1:0]     corner;
      logic [PITCH_W-1:0]    pitch;
   } blit_step_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [COLOR_W-1:0]    req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [55:0]           rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Table row that the texel on req_tdata belongs to, or -1 for a texel
   // whose writes come from the predictor. Driven together with req_tdata.
   int req_row = -1;

   atlas_blit_with_edge_border_unit #(.MAX_DIM(MAX_DIM)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),     // texel_color[31:0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),     // dest_address[23:0], write_color[55:24]
      .rsp_tlast  (rsp_tlast),     // last_of_run
      .rsp_tuser  (rsp_tuser),     // texture_done
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Blit predictor. It keeps its own copy of the registers and of the source
   // position, and is advanced by the monitor on every accepted texel.
   // ------------------------------------------------------------------------
   logic [DIM_REG_W-1:0] tex_w_q, tex_h_q;
   logic [PITCH_W-1:0]   pitch_q, dest_col_q;
   logic [DIM_REG_W-1:0] src_x, src_y;
   logic [ADDR_W-1:0]    row_base;

   atlas_write_t pending_writes[$];   // writes still owed by the block
   blit_step_t   directed_rows[$];
   int           mismatch_count = 0;

   // Sizes of zero count as one and sizes past the limit as the limit.
   function automatic logic [DIM_REG_W-1:0] dim_of(logic [DIM_REG_W-1:0] v);
      if (v == '0) return DIM_REG_W'(1);
      if (v > MAX_DIM) return DIM_REG_W'(MAX_DIM);
      return v;
   endfunction

   // Works out the writes of one texel, queues them when keep is set, and
   // steps the source position. Writes go row by row (above, own, below) and
   // within a row from left to right; all arithmetic wraps at 24 bits.
   function automatic void blit_texel(logic [COLOR_W-1:0] color, bit keep);
      logic [DIM_REG_W-1:0] w, h;
      bit                   left, right, top, bottom, done;
      logic [ADDR_W-1:0]    col0;
      atlas_write_t         wr;
      atlas_write_t         batch[$];
      w      = dim_of(tex_w_q);
      h      = dim_of(tex_h_q);
      left   = (src_x == '0);
      right  = (src_x >= w - 1'b1);
      top    = (src_y == '0);
      bottom = (src_y >= h - 1'b1);
      done   = right && bottom;
      col0   = ADDR_W'(dest_col_q) + ADDR_W'(src_x) - 1'b1;
      for (int r = 0; r < 3; r++) begin
         if ((r == 0 && !top) || (r == 2 && !bottom)) continue;
         for (int c = 0; c < 3; c++) begin
            if ((c == 0 && !left) || (c == 2 && !right)) continue;
            wr.addr  = row_base + ADDR_W'(r) * ADDR_W'(pitch_q) + col0 + ADDR_W'(c);
            wr.color = color;
            wr.last  = 1'b0;
            wr.done  = 1'b0;
            batch.push_back(wr);
         end
      end
      wr = batch.pop_back();
      wr.last = 1'b1;
      wr.done = done;
      batch.push_back(wr);
      if (keep) begin
         foreach (batch[i]) pending_writes.push_back(batch[i]);
      end
      // A position at or past the last column or row counts as that edge.
      if (!right) begin
         src_x = src_x + 1'b1;
      end else if (!bottom) begin
         src_x    = '0;
         src_y    = src_y + 1'b1;
         row_base = row_base + ADDR_W'(pitch_q);
      end else begin
         src_x    = '0;
         src_y    = '0;
         row_base = '0;
      end
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < 50)
         $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Monitor. Everything is sampled at the rising edge, before the block and
   // the driver have moved on, so a handshake seen here is the one that just
   // completed. It also runs the watchdog on handshake activity.
   // ------------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      atlas_write_t want;
      blit_step_t   row;
      if (reset) begin
         tex_w_q    <= DIM_REG_W'(1);
         tex_h_q    <= DIM_REG_W'(1);
         pitch_q    <= PITCH_W'(3);
         dest_col_q <= PITCH_W'(1);
         src_x      <= '0;
         src_y      <= '0;
         row_base   <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TEX_WIDTH:   tex_w_q    = csr_data[DIM_REG_W-1:0];
               CSR_TEX_HEIGHT:  tex_h_q    = csr_data[DIM_REG_W-1:0];
               CSR_ATLAS_WIDTH: pitch_q    = csr_data;
               CSR_DEST_COLUMN: dest_col_q = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_row >= 0) begin
               // Directed 1x1 case: the 3x3 block is written out by hand and
               // the predictor only keeps its position in step.
               row = directed_rows[req_row];
               for (int r = 0; r < 3; r++) begin
                  for (int c = 0; c < 3; c++) begin
                     want.addr  = row.corner + ADDR_W'(r) * ADDR_W'(row.pitch) + ADDR_W'(c);
                     want.color = row.color;
                     want.last  = (r == 2 && c == 2);
                     want.done  = (r == 2 && c == 2);
                     pending_writes.push_back(want);
                  end
               end
               blit_texel(req_tdata, 1'b0);
            end else begin
               blit_texel(req_tdata, 1'b1);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_writes.size() == 0) begin
               report_mismatch("write with nothing owed, address", 32'(rsp_tdata[23:0]), 0);
            end else begin
               want = pending_writes.pop_front();
               if (rsp_tdata[23:0] !== want.addr)
                  report_mismatch("dest_address", 32'(rsp_tdata[23:0]), 32'(want.addr));
               if (rsp_tdata[55:24] !== want.color)
                  report_mismatch("write_color", rsp_tdata[55:24], want.color);
               if (rsp_tlast !== want.last)
                  report_mismatch("last_of_run", 32'(rsp_tlast), 32'(want.last));
               if (rsp_tuser !== want.done)
                  report_mismatch("texture_done", 32'(rsp_tuser), 32'(want.done));
            end
         end
         if ((csr_valid && csr_ready) || (req_tvalid && req_tready) ||
             (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver. rsp_tready is redrawn every cycle against the stall rate of
   // the current phase.
   // ------------------------------------------------------------------------
   int sink_stall_pct = 0;
   int sender_idle_pct = 0;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   // ------------------------------------------------------------------------
   // Driver tasks. Each one is entered right after a rising edge and returns
   // right after the edge at which its handshake completed, leaving the valid
   // high so that back-to-back items never drop it for a step.
   // ------------------------------------------------------------------------

   // Size registers as written by the driver; used to plan how many texels
   // finish the current sub-texture without reading the monitor's copy while
   // it may be updating.
   logic [DIM_REG_W-1:0] plan_tex_w = DIM_REG_W'(1);
   logic [DIM_REG_W-1:0] plan_tex_h = DIM_REG_W'(1);

   task automatic send_texel(logic [COLOR_W-1:0] color, int row);
      csr_valid <= 1'b0;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= color;
      req_row    <= row;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      if (index == CSR_TEX_WIDTH)  plan_tex_w = data[DIM_REG_W-1:0];
      if (index == CSR_TEX_HEIGHT) plan_tex_h = data[DIM_REG_W-1:0];
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Stops both senders and waits until every owed write has come back. It
   // always waits on the clock before it checks, so that a texel taken in
   // this very step has been seen by the monitor first.
   task automatic drain_writes();
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      do @(posedge clock); while (pending_writes.size() != 0);
   endtask

   // Texels still needed to reach the end of the sub-texture from the
   // current position, with a position past an edge counting as that edge.
   function automatic int texels_to_finish();
      int w, h, row_rest, rows_left;
      w = int'(dim_of(plan_tex_w));
      h = int'(dim_of(plan_tex_h));
      row_rest  = (int'(src_x) >= w - 1) ? 1 : w - int'(src_x);
      rows_left = (int'(src_y) >= h - 1) ? 0 : h - 1 - int'(src_y);
      return row_rest + rows_left * w;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_dim();
      int r;
      r = $urandom_range(99);
      if (r < 5)  return '0;
      if (r < 80) return CSR_DATA_W'($urandom_range(1, 6));
      if (r < 92) return CSR_DATA_W'($urandom_range(7, 16));
      if (r < 96) return CSR_DATA_W'(MAX_DIM);
      return CSR_DATA_W'($urandom_range(0, 1023));
   endfunction

   function automatic void add_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      blit_step_t s;
      s = '{default: '0};
      s.is_reg = 1'b1;
      s.index  = index;
      s.data   = data;
      directed_rows.push_back(s);
   endfunction

   function automatic void add_texel(logic [COLOR_W-1:0] color, bit typed,
                                     logic [ADDR_W-1:0] corner, logic [PITCH_W-1:0] pitch);
      blit_step_t s;
      s = '{default: '0};
      s.color  = color;
      s.typed  = typed;
      s.corner = corner;
      s.pitch  = pitch;
      directed_rows.push_back(s);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------------
   initial begin
      int phase, random_items, count, r;

      // Directed table. The registers come out of reset as a 1x1 texture at
      // column 1 with pitch 3, so the first texel fills addresses 0 to 8.
      add_texel(32'h0000_0000, 1'b1, 24'd0, 14'd3);
      add_texel(32'hFFFF_FFFF, 1'b1, 24'd0, 14'd3);
      // Widest legal pitch and rightmost legal column.
      add_reg(CSR_ATLAS_WIDTH, 14'd16000);
      add_reg(CSR_DEST_COLUMN, 14'd16000);
      add_texel(32'hA5A5_A5A5, 1'b1, 24'd15999, 14'd16000);
      // Zero sizes are taken as one, so these stay 1x1 blocks.
      add_reg(CSR_TEX_WIDTH, 14'd0);
      add_texel(32'h5A5A_5A5A, 1'b1, 24'd15999, 14'd16000);
      add_reg(CSR_TEX_HEIGHT, 14'd0);
      add_texel(32'h8000_0001, 1'b1, 24'd15999, 14'd16000);
      // A 3x2 texture: corners, a top edge and a bottom edge texel.
      add_reg(CSR_TEX_WIDTH, 14'd3);
      add_reg(CSR_TEX_HEIGHT, 14'd2);
      add_reg(CSR_ATLAS_WIDTH, 14'd8);
      add_reg(CSR_DEST_COLUMN, 14'd2);
      add_texel(32'h0102_0304, 1'b0, '0, '0);
      add_texel(32'h1122_3344, 1'b0, '0, '0);
      add_texel(32'h5566_7788, 1'b0, '0, '0);
      add_texel(32'h99AA_BBCC, 1'b0, '0, '0);
      add_texel(32'hDDEE_FF00, 1'b0, '0, '0);
      add_texel(32'h7F7F_7F7F, 1'b0, '0, '0);
      // Largest sizes with every register bit set, then the size shrinks
      // under a texture in progress so the position lies past the new edge.
      add_reg(CSR_TEX_WIDTH, 14'h3FFF);
      add_reg(CSR_TEX_HEIGHT, 14'h3FFF);
      add_reg(CSR_ATLAS_WIDTH, 14'h3FFF);
      add_reg(CSR_DEST_COLUMN, 14'h3FFF);
      add_texel(32'hC3C3_C3C3, 1'b0, '0, '0);
      add_texel(32'h3C3C_3C3C, 1'b0, '0, '0);
      add_reg(CSR_TEX_WIDTH, 14'd1);
      add_texel(32'h0F0F_0F0F, 1'b0, '0, '0);
      add_reg(CSR_TEX_HEIGHT, 14'd1);
      add_texel(32'hF0F0_F0F0, 1'b0, '0, '0);
      // Back at the origin: a 1x1 block at the out-of-range pitch.
      add_texel(32'h1234_5678, 1'b1, 24'd16382, 14'h3FFF);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_reg) begin
            drain_writes();
            write_register(directed_rows[i].index, directed_rows[i].data);
         end else begin
            send_texel(directed_rows[i].color, directed_rows[i].typed ? i : -1);
         end
      end

      // Random phases. Every phase starts idle, rewrites some registers and
      // then sends texels: mostly the rest of a sub-texture, sometimes a
      // short broken run that leaves the position in the middle.
      phase = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         drain_writes();
         case (phase % 4)
            0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin sender_idle_pct = 55; sink_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  sink_stall_pct = 55; end
            default: begin sender_idle_pct = 7; sink_stall_pct = 7; end
         endcase
         r = $urandom_range(99);
         if (phase == STRIP_PHASE) begin
            // A one-texel-wide strip at the widest pitch, so every texel is
            // a left and a right edge at once.
            write_register(CSR_TEX_WIDTH, 14'd1);
            write_register(CSR_TEX_HEIGHT, 14'd24);
            write_register(CSR_ATLAS_WIDTH, 14'h3FFF);
            write_register(CSR_DEST_COLUMN, 14'h3FFF);
            count = texels_to_finish();
         end else if (r < 75) begin
            write_register(CSR_TEX_WIDTH, pick_dim());
            write_register(CSR_TEX_HEIGHT, pick_dim());
            r = $urandom_range(99);
            if (r < 60)
               write_register(CSR_ATLAS_WIDTH, CSR_DATA_W'($urandom_range(3, 40)));
            else if (r < 75) write_register(CSR_ATLAS_WIDTH, 14'd3);
            else if (r < 85) write_register(CSR_ATLAS_WIDTH, 14'd16000);
            else
               write_register(CSR_ATLAS_WIDTH, CSR_DATA_W'($urandom_range(3, 16000)));
            r = $urandom_range(99);
            if (r < 40)      write_register(CSR_DEST_COLUMN, 14'd1);
            else if (r < 70)
               write_register(CSR_DEST_COLUMN, CSR_DATA_W'($urandom_range(1, 64)));
            else if (r < 85) write_register(CSR_DEST_COLUMN, 14'd16000);
            else
               write_register(CSR_DEST_COLUMN, CSR_DATA_W'($urandom_range(1, 16000)));
            count = texels_to_finish();
            if (count > PHASE_CAP) count = PHASE_CAP;
         end else begin
            // Raw register writes with any index and any data bits.
            repeat ($urandom_range(1, 2))
               write_register(CSR_IDX_W'($urandom_range(0, 3)),
                              CSR_DATA_W'($urandom_range(0, 16383)));
            count = $urandom_range(1, 8);
         end
         for (int k = 0; k < count; k++) begin
            // Now and then the sender holds off until the block has caught up.
            if ($urandom_range(99) < 3) drain_writes();
            send_texel($urandom, -1);
            random_items++;
         end
         phase++;
      end

      drain_writes();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
